// File: sv/hil_pkg.sv
// Shared types and constants for the homography inlier scorer.
`default_nettype none

package hil_pkg;

  // Width of one digit in the pipelined multipliers.
  localparam int DIGIT_BITS = 32;

  localparam int FIELD_W    = 32;
  localparam int TOTAL_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] src_x;
    logic signed [FIELD_W-1:0] src_y;
    logic signed [FIELD_W-1:0] src_w;
    logic signed [FIELD_W-1:0] dst_x;
    logic signed [FIELD_W-1:0] dst_y;
    logic signed [FIELD_W-1:0] dst_w;
    logic                      last_pair;
  } in_word_t;

  typedef struct packed {
    logic               is_inlier;
    logic [TOTAL_W-1:0] inlier_total;
    logic               set_done;
  } out_word_t;

  // Control that travels alongside the arithmetic through every stage.
  typedef struct packed {
    logic vld;
    logic last;
    logic w_nz;
  } side_t;

endpackage

`default_nettype wire

// File: sv/hil_smul.sv
// Pipelined signed multiplier built from 32x32 digit products and a registered adder tree.
`default_nettype none

module hil_smul
  import hil_pkg::*;
#(
  parameter int A_W = 64,
  parameter int B_W = 32,
  parameter int LV  = 1
) (
  input  logic                       clk,
  input  logic signed [A_W-1:0]      a,
  input  logic signed [B_W-1:0]      b,
  output logic signed [A_W+B_W-1:0]  p
);

  localparam int NA   = (A_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NB   = (B_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NPP  = NA * NB;
  localparam int NP   = 1 << LV;
  localparam int P_W  = A_W + B_W;
  localparam int AP_W = NA * DIGIT_BITS;
  localparam int BP_W = NB * DIGIT_BITS;

  logic [A_W-1:0]          a_abs;
  logic [B_W-1:0]          b_abs;
  logic [AP_W-1:0]         mag_a_r;
  logic [BP_W-1:0]         mag_b_r;
  logic [LV+1:0]           neg_r;
  logic [2*DIGIT_BITS-1:0] prod_r [NP];
  logic [P_W-1:0]          leaf   [NP];
  logic [P_W-1:0]          node_r [NP-1];
  logic [P_W-1:0]          val    [2*NP-1];
  logic signed [P_W-1:0]   p_r;

  // Work on magnitudes; the sign is restored after the tree.
  assign a_abs = a[A_W-1] ? A_W'(-a) : A_W'(a);
  assign b_abs = b[B_W-1] ? B_W'(-b) : B_W'(b);

  always_ff @(posedge clk) begin
    mag_a_r  <= AP_W'(a_abs);
    mag_b_r  <= BP_W'(b_abs);
    neg_r[0] <= a[A_W-1] ^ b[B_W-1];
    for (int k = 1; k <= LV + 1; k++) begin
      neg_r[k] <= neg_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int idx = 0; idx < NP; idx++) begin
      if (idx < NPP) begin
        prod_r[idx] <= mag_a_r[(idx / NB) * DIGIT_BITS +: DIGIT_BITS]
                     * mag_b_r[(idx % NB) * DIGIT_BITS +: DIGIT_BITS];
      end else begin
        prod_r[idx] <= '0;
      end
    end
  end

  always_comb begin
    for (int idx = 0; idx < NP; idx++) begin
      leaf[idx] = P_W'(prod_r[idx]) << (DIGIT_BITS * ((idx / NB) + (idx % NB)));
    end
    for (int k = 0; k < NP - 1; k++) begin
      val[k] = node_r[k];
    end
    for (int idx = 0; idx < NP; idx++) begin
      val[NP-1+idx] = leaf[idx];
    end
  end

  // Heap-ordered tree: node k sums nodes 2k+1 and 2k+2, one level per cycle.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NP - 1; k++) begin
      node_r[k] <= val[2*k+1] + val[2*k+2];
    end
  end

  always_ff @(posedge clk) begin
    p_r <= neg_r[LV+1] ? -$signed(node_r[0]) : $signed(node_r[0]);
  end

  assign p = p_r;

endmodule

`default_nettype wire

// File: sv/hil_proj.sv
// Projection stages: maps the source point through the homography and forms threshold*dst_w.
`default_nettype none

module hil_proj
  import hil_pkg::*;
#(
  parameter int FB        = 32,
  parameter int FRAC_BITS = 24,
  parameter int PB        = 66,
  parameter int TDB       = 65
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  side_t                 in_side,
  input  logic signed [FB-1:0]  x,
  input  logic signed [FB-1:0]  y,
  input  logic signed [FB-1:0]  w,
  input  logic signed [FB-1:0]  dx,
  input  logic signed [FB-1:0]  dy,
  input  logic signed [FB-1:0]  dw,
  input  logic signed [FB-1:0]  coef [8],
  input  logic [FB-1:0]         thr,
  output side_t                 out_side,
  output logic signed [PB-1:0]  px,
  output logic signed [PB-1:0]  py,
  output logic signed [PB-1:0]  pw,
  output logic signed [TDB-1:0] td,
  output logic signed [FB-1:0]  dx_o,
  output logic signed [FB-1:0]  dy_o,
  output logic signed [FB-1:0]  dw_o
);

  side_t                 side1_r, side2_r;
  logic signed [2*FB-1:0] mul_r [8];
  logic signed [PB-1:0]  wsh_r;
  logic signed [TDB-1:0] td1_r, td2_r;
  logic signed [FB-1:0]  dx1_r, dy1_r, dw1_r, dx2_r, dy2_r, dw2_r;
  logic signed [PB-1:0]  px_r, py_r, pw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r <= '0;
      side2_r <= '0;
    end else begin
      side1_r <= in_side;
      side2_r <= side1_r;
    end
  end

  // First stage: one product per coefficient, and h22 = 1 as a plain shift.
  always_ff @(posedge clk) begin
    mul_r[0] <= coef[0] * x;
    mul_r[1] <= coef[1] * y;
    mul_r[2] <= coef[2] * w;
    mul_r[3] <= coef[3] * x;
    mul_r[4] <= coef[4] * y;
    mul_r[5] <= coef[5] * w;
    mul_r[6] <= coef[6] * x;
    mul_r[7] <= coef[7] * y;
    wsh_r    <= PB'(w) <<< FRAC_BITS;
    td1_r    <= $signed({1'b0, thr}) * dw;
    dx1_r    <= dx;
    dy1_r    <= dy;
    dw1_r    <= dw;
  end

  always_ff @(posedge clk) begin
    px_r  <= PB'(mul_r[0]) + PB'(mul_r[1]) + PB'(mul_r[2]);
    py_r  <= PB'(mul_r[3]) + PB'(mul_r[4]) + PB'(mul_r[5]);
    pw_r  <= PB'(mul_r[6]) + PB'(mul_r[7]) + wsh_r;
    td2_r <= td1_r;
    dx2_r <= dx1_r;
    dy2_r <= dy1_r;
    dw2_r <= dw1_r;
  end

  assign out_side = side2_r;
  assign px       = px_r;
  assign py       = py_r;
  assign pw       = pw_r;
  assign td       = td2_r;
  assign dx_o     = dx2_r;
  assign dy_o     = dy2_r;
  assign dw_o     = dw2_r;

endmodule

`default_nettype wire

// File: sv/hil_resid.sv
// Residual stages: cross-multiplied errors ex, ey and the scaled weight product.
`default_nettype none

module hil_resid
  import hil_pkg::*;
#(
  parameter int FB  = 32,
  parameter int PB  = 66,
  parameter int TDB = 65,
  parameter int LV  = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  side_t                     in_side,
  input  logic signed [PB-1:0]      px,
  input  logic signed [PB-1:0]      py,
  input  logic signed [PB-1:0]      pw,
  input  logic signed [TDB-1:0]     td,
  input  logic signed [FB-1:0]      dx,
  input  logic signed [FB-1:0]      dy,
  input  logic signed [FB-1:0]      dw,
  output side_t                     out_side,
  output logic signed [PB+FB:0]     ex,
  output logic signed [PB+FB:0]     ey,
  output logic signed [PB+TDB-1:0]  q
);

  localparam int ML = 3 + LV;
  localparam int EB = PB + FB + 1;
  localparam int QB = PB + TDB;

  logic signed [PB+FB-1:0] pxdw, dxpw, pydw, dypw;
  logic signed [QB-1:0]    q_p;
  side_t                   side_d_r [ML];
  side_t                   side_r;
  logic signed [EB-1:0]    ex_r, ey_r;
  logic signed [QB-1:0]    q_r;

  hil_smul #(.A_W(PB), .B_W(FB), .LV(LV)) u_pxdw (.clk(clk), .a(px), .b(dw), .p(pxdw));
  hil_smul #(.A_W(PB), .B_W(FB), .LV(LV)) u_dxpw (.clk(clk), .a(pw), .b(dx), .p(dxpw));
  hil_smul #(.A_W(PB), .B_W(FB), .LV(LV)) u_pydw (.clk(clk), .a(py), .b(dw), .p(pydw));
  hil_smul #(.A_W(PB), .B_W(FB), .LV(LV)) u_dypw (.clk(clk), .a(pw), .b(dy), .p(dypw));
  hil_smul #(.A_W(PB), .B_W(TDB), .LV(LV)) u_q   (.clk(clk), .a(pw), .b(td), .p(q_p));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ML; k++) begin
        side_d_r[k] <= '0;
      end
      side_r <= '0;
    end else begin
      side_d_r[0] <= in_side;
      for (int k = 1; k < ML; k++) begin
        side_d_r[k] <= side_d_r[k-1];
      end
      side_r <= side_d_r[ML-1];
    end
  end

  always_ff @(posedge clk) begin
    ex_r <= EB'(pxdw) - EB'(dxpw);
    ey_r <= EB'(pydw) - EB'(dypw);
    q_r  <= q_p;
  end

  assign out_side = side_r;
  assign ex       = ex_r;
  assign ey       = ey_r;
  assign q        = q_r;

endmodule

`default_nettype wire

// File: sv/hil_test.sv
// Decision stages: squares the errors and the scaled weight and compares them.
`default_nettype none

module hil_test
  import hil_pkg::*;
#(
  parameter int EB        = 99,
  parameter int QB        = 131,
  parameter int FRAC_BITS = 24,
  parameter int LV        = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  side_t                in_side,
  input  logic signed [EB-1:0] ex,
  input  logic signed [EB-1:0] ey,
  input  logic signed [QB-1:0] q,
  output side_t                out_side,
  output logic                 inl
);

  localparam int ML = 3 + LV;
  localparam int SW = 2 * EB + 1;
  localparam int LW = SW + 2 * FRAC_BITS;
  localparam int QW = 2 * QB;
  localparam int CW = (LW > QW) ? LW : QW;

  logic signed [2*EB-1:0] exx, eyy;
  logic signed [QW-1:0]   qq;
  side_t                  side_d_r [ML];
  side_t                  side_a_r, side_b_r;
  logic [SW-1:0]          sum_r;
  logic [QW-1:0]          q2_r;
  logic                   inl_r;

  hil_smul #(.A_W(EB), .B_W(EB), .LV(LV)) u_exx (.clk(clk), .a(ex), .b(ex), .p(exx));
  hil_smul #(.A_W(EB), .B_W(EB), .LV(LV)) u_eyy (.clk(clk), .a(ey), .b(ey), .p(eyy));
  hil_smul #(.A_W(QB), .B_W(QB), .LV(LV)) u_qq  (.clk(clk), .a(q), .b(q), .p(qq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ML; k++) begin
        side_d_r[k] <= '0;
      end
      side_a_r <= '0;
      side_b_r <= '0;
    end else begin
      side_d_r[0] <= in_side;
      for (int k = 1; k < ML; k++) begin
        side_d_r[k] <= side_d_r[k-1];
      end
      side_a_r <= side_d_r[ML-1];
      side_b_r <= side_a_r;
    end
  end

  // Squares are never negative, so both sides compare as unsigned.
  always_ff @(posedge clk) begin
    sum_r <= SW'($unsigned(exx)) + SW'($unsigned(eyy));
    q2_r  <= $unsigned(qq);
    inl_r <= (CW'({sum_r, {(2*FRAC_BITS){1'b0}}}) < CW'(q2_r)) && side_a_r.w_nz;
  end

  assign out_side = side_b_r;
  assign inl      = inl_r;

endmodule

`default_nettype wire

// File: sv/homography_inlier_scorer_top.sv
// Top level of the homography inlier scorer: configuration, pipeline, tally and result queue.
//
// Usage: load the homography (h22 is fixed at 1) and the distance threshold through the
// cfg_ port while no word is in flight. Each input word on the in_ channel carries one
// correspondence; each produces exactly one result word on the out_ channel, in order,
// with the inlier flag, the running inlier count of the current set and a copy of
// last_pair. The count saturates and returns to zero after the word that ends a set.
// The two multiplier trees (LVB and LVD levels) set the pipeline depth from acceptance
// to out_valid. Throughput is one word per clock while in_ready is high.
// The arithmetic pipeline never stalls. Results collect in a small queue, and in_ready
// is withheld only when every queue slot is already owed to a word in flight, so a
// receiver that stalls on out_ready loses nothing and the input keeps flowing until the
// queue is committed. Reset is synchronous: it restores the configuration defaults
// (zero coefficients, threshold 0.005), clears the tally, the queue and all valid bits.
`default_nettype none

module homography_inlier_scorer_top
  import hil_pkg::*;
#(
  parameter int WORD_BITS  = 32,
  parameter int FRAC_BITS  = 24,
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Only the low FB bits of every field and coefficient are significant.
  localparam int FB  = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
  // Projected components: each sums three terms, products or the shifted weight term.
  localparam int PB  = ((2 * FB > FB + FRAC_BITS + 1) ? 2 * FB : FB + FRAC_BITS + 1) + 2;
  localparam int TDB = 2 * FB + 1;
  localparam int EB  = PB + FB + 1;
  localparam int QB  = PB + TDB;

  localparam int NDP = (PB + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NDF = (FB + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NDT = (TDB + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NDE = (EB + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NDQ = (QB + DIGIT_BITS - 1) / DIGIT_BITS;

  localparam int LB1 = $clog2(NDP * NDF);
  localparam int LB2 = $clog2(NDP * NDT);
  localparam int LBM = (LB1 > LB2) ? LB1 : LB2;
  localparam int LVB = (LBM > 1) ? LBM : 1;
  localparam int LD1 = $clog2(NDE * NDE);
  localparam int LD2 = $clog2(NDQ * NDQ);
  localparam int LDM = (LD1 > LD2) ? LD1 : LD2;
  localparam int LVD = (LDM > 1) ? LDM : 1;

  // Cycles from acceptance to the result showing on out_valid.
  localparam int LAT   = 2 + (4 + LVB) + (5 + LVD) + 1;
  localparam int QD    = LAT + 2;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  // Threshold default: 0.005 rounded to FRAC_BITS fraction bits.
  localparam longint unsigned THR_FULL = ((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam logic [FIELD_W-1:0] THR_RST = THR_FULL[FIELD_W-1:0];

  // Configuration registers.
  logic [CFG_DATA_W-1:0] row0a_r, row0b_r, row1_r, row2_r;
  logic [FIELD_W-1:0]    thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0a_r <= '0;
      row0b_r <= '0;
      row1_r  <= '0;
      row2_r  <= '0;
      thr_r   <= THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_A: row0a_r <= cfg_data;
        REG_ROW0_B: row0b_r <= cfg_data;
        REG_ROW1:   row1_r  <= cfg_data;
        REG_ROW2:   row2_r  <= cfg_data;
        REG_THRESH: thr_r   <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Each 64-bit register holds two coefficients, the first in the upper half.
  logic signed [FB-1:0] coef [8];

  always_comb begin
    coef[0] = $signed(row0a_r[FIELD_W +: FB]);
    coef[1] = $signed(row0a_r[0 +: FB]);
    coef[2] = $signed(row0b_r[FIELD_W +: FB]);
    coef[3] = $signed(row0b_r[0 +: FB]);
    coef[4] = $signed(row1_r[FIELD_W +: FB]);
    coef[5] = $signed(row1_r[0 +: FB]);
    coef[6] = $signed(row2_r[FIELD_W +: FB]);
    coef[7] = $signed(row2_r[0 +: FB]);
  end

  // Input side: every accepted word starts down the pipeline with its valid bit.
  logic                 in_acc, out_acc;
  side_t                in_side;
  logic signed [FB-1:0] src_w_f;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign src_w_f = $signed(in_word.src_w[FB-1:0]);

  always_comb begin
    in_side.vld  = in_acc;
    in_side.last = in_word.last_pair;
    in_side.w_nz = (src_w_f != '0);
  end

  side_t                 proj_side, resid_side, tail_side;
  logic signed [PB-1:0]  px, py, pw;
  logic signed [TDB-1:0] td;
  logic signed [FB-1:0]  dx, dy, dw;
  logic signed [EB-1:0]  ex, ey;
  logic signed [QB-1:0]  q;
  logic                  tail_inl;

  hil_proj #(
    .FB(FB), .FRAC_BITS(FRAC_BITS), .PB(PB), .TDB(TDB)
  ) u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_side (in_side),
    .x       ($signed(in_word.src_x[FB-1:0])),
    .y       ($signed(in_word.src_y[FB-1:0])),
    .w       (src_w_f),
    .dx      ($signed(in_word.dst_x[FB-1:0])),
    .dy      ($signed(in_word.dst_y[FB-1:0])),
    .dw      ($signed(in_word.dst_w[FB-1:0])),
    .coef    (coef),
    .thr     (thr_r[FB-1:0]),
    .out_side(proj_side),
    .px      (px),
    .py      (py),
    .pw      (pw),
    .td      (td),
    .dx_o    (dx),
    .dy_o    (dy),
    .dw_o    (dw)
  );

  hil_resid #(
    .FB(FB), .PB(PB), .TDB(TDB), .LV(LVB)
  ) u_resid (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_side (proj_side),
    .px      (px),
    .py      (py),
    .pw      (pw),
    .td      (td),
    .dx      (dx),
    .dy      (dy),
    .dw      (dw),
    .out_side(resid_side),
    .ex      (ex),
    .ey      (ey),
    .q       (q)
  );

  hil_test #(
    .EB(EB), .QB(QB), .FRAC_BITS(FRAC_BITS), .LV(LVD)
  ) u_test (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_side (resid_side),
    .ex      (ex),
    .ey      (ey),
    .q       (q),
    .out_side(tail_side),
    .inl     (tail_inl)
  );

  // Tally at the tail: words arrive here in order, so the count is exact.
  logic [COUNT_BITS-1:0] tally_r, count_nxt;
  logic                  tally_inc;

  always_comb begin
    tally_inc = tail_inl && (tally_r != {COUNT_BITS{1'b1}});
    count_nxt = tally_r + COUNT_BITS'(tally_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else if (tail_side.vld) begin
      tally_r <= tail_side.last ? '0 : count_nxt;
    end
  end

  // Result queue. The credit counter covers words in the pipeline and in the queue,
  // so a word is accepted only when a slot is guaranteed for its result.
  out_word_t        q_mem [QD];
  out_word_t        tail_word;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] q_cnt_r, credit_r;

  always_comb begin
    tail_word.is_inlier    = tail_inl;
    tail_word.inlier_total = TOTAL_W'(count_nxt);
    tail_word.set_done     = tail_side.last;
  end

  always_ff @(posedge clk) begin
    if (tail_side.vld) begin
      q_mem[wr_ptr_r] <= tail_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      credit_r <= '0;
    end else begin
      if (tail_side.vld) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      q_cnt_r  <= q_cnt_r + CNT_W'(tail_side.vld) - CNT_W'(out_acc);
      credit_r <= credit_r + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  assign in_ready  = (credit_r < CNT_W'(QD));
  assign out_valid = (q_cnt_r != '0);
  assign out_word  = q_mem[rd_ptr_r];

  // The credit never promises more slots than the queue has.
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CNT_W'(QD))
    else $error("credit count exceeds queue depth");

  // Every queued result belongs to a word that the credit still counts.
  a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= credit_r)
    else $error("queue holds more results than words in flight");

  // The word that ends a set leaves the tally at zero.
  a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_side.vld && tail_side.last) |=> (tally_r == '0))
    else $error("tally not cleared after end of set");

  // Within a set the tally moves by at most one per word.
  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_side.vld && !tail_side.last) |=>
      (tally_r == $past(tally_r) || tally_r == $past(tally_r) + 1'b1))
    else $error("tally moved by more than one");

  // Without a word at the tail the tally holds.
  a_tally_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !tail_side.vld |=> $stable(tally_r))
    else $error("tally changed with no word at the tail");

endmodule

`default_nettype wire

// File: tb/homography_inlier_scorer_top_tb.sv
// Self-checking testbench for the homography inlier scorer: directed and random correspondences.
`timescale 1ns / 1ps

module homography_inlier_scorer_top_tb;
  import hil_pkg::*;

  // Pipeline depth of the scorer, from acceptance to out_valid.
  localparam int PIPE_LATENCY   = 21;
  localparam int FRAC_SHIFT     = 24;
  // Cycles with no word accepted on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 320;
  localparam int PHASE_COUNT    = 6;
  localparam logic [31:0] Q_ONE          = 32'h0100_0000;
  localparam logic [31:0] DEFAULT_THRESH = 32'd83886;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the configuration and of the per-set inlier tally.
  logic [CFG_DATA_W-1:0] coef_regs [4];
  logic [31:0]           thresh_reg;
  logic [TOTAL_W-1:0]    set_tally;

  // Scores predicted for accepted words, oldest first.
  out_word_t expected_scores [$];
  out_word_t want;
  int        fail_count = 0;
  int        quiet_cycles = 0;
  bit        in_idle_en = 1'b1;
  bit        out_stall_en = 1'b1;

  always #4 clk = ~clk;

  homography_inlier_scorer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Sign-extends one Q7.24 quantity to a width where no product of the scoring can overflow.
  function automatic logic signed [511:0] widen(input logic signed [31:0] v);
    return v;
  endfunction

  // Random offset in [-span, span] as a 32-bit two's complement pattern.
  function automatic logic [31:0] jitter(input int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Maps the source point through the shadow homography; h22 is 1.0 at the fixed-point scale.
  function automatic void project_point(input in_word_t w,
                                        output logic signed [511:0] px, py, pw);
    logic signed [511:0] h [8];
    logic signed [511:0] x, y, s;
    for (int i = 0; i < 4; i++) begin
      h[2*i]   = widen(coef_regs[i][63:32]);
      h[2*i+1] = widen(coef_regs[i][31:0]);
    end
    x  = widen(w.src_x);
    y  = widen(w.src_y);
    s  = widen(w.src_w);
    px = h[0] * x + h[1] * y + h[2] * s;
    py = h[3] * x + h[4] * y + h[5] * s;
    pw = h[6] * x + h[7] * y + (s <<< FRAC_SHIFT);
  endfunction

  // Exact inlier test without division, then the saturating tally that clears after a set.
  function automatic out_word_t score_pair(input in_word_t w);
    logic signed [511:0] px, py, pw, dx, dy, dw, ex, ey, err_sq, bound;
    logic                hit;
    out_word_t           r;
    project_point(w, px, py, pw);
    dx = widen(w.dst_x);
    dy = widen(w.dst_y);
    dw = widen(w.dst_w);
    ex = px * dw - dx * pw;
    ey = py * dw - dy * pw;
    err_sq = (ex * ex + ey * ey) <<< (2 * FRAC_SHIFT);
    bound = '0;
    bound[31:0] = thresh_reg;
    bound = bound * pw * dw;
    bound = bound * bound;
    // A zero source weight leaves nothing to dehomogenize, so such a word never counts.
    hit = (err_sq < bound) && (w.src_w != 0);
    if (hit && set_tally != '1) begin
      set_tally = set_tally + 1'b1;
    end
    r.is_inlier    = hit;
    r.inlier_total = set_tally;
    r.set_done     = w.last_pair;
    if (w.last_pair) begin
      set_tally = '0;
    end
    return r;
  endfunction

  // Drivers change on the falling edge; the block samples them on the rising edge.
  always @(negedge clk) begin
    out_ready = !(out_stall_en && $urandom_range(0, 99) < 11);
  end

  // Every result word accepted on the out_ channel is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_scores.size() == 0) begin
        $error("result word with no prediction waiting: %p", out_word);
        fail_count++;
      end else begin
        want = expected_scores.pop_front();
        if (out_word.is_inlier !== want.is_inlier) begin
          $error("is_inlier: expected %0d, got %0d", want.is_inlier, out_word.is_inlier);
          fail_count++;
        end
        if (out_word.inlier_total !== want.inlier_total) begin
          $error("inlier_total: expected %0d, got %0d", want.inlier_total,
                 out_word.inlier_total);
          fail_count++;
        end
        if (out_word.set_done !== want.set_done) begin
          $error("set_done: expected %0d, got %0d", want.set_done, out_word.set_done);
          fail_count++;
        end
      end
    end
  end

  // A run in which neither channel moves for this long is hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one word, optionally after random idle cycles, and predicts its score on acceptance.
  // Valid drops after acceptance; a following call raises it again in the same falling edge,
  // so back-to-back words still stream at one per cycle while in_ready is high.
  task automatic send_pair(input in_word_t w);
    while (in_idle_en && $urandom_range(0, 99) < 11) begin
      @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_scores.push_back(score_pair(w));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Holds off new words until every predicted result has been seen, plus the pipeline depth.
  task automatic wait_drained();
    while (expected_scores.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ROW0_A: coef_regs[0] = data;
      REG_ROW0_B: coef_regs[1] = data;
      REG_ROW1:   coef_regs[2] = data;
      REG_ROW2:   coef_regs[3] = data;
      REG_THRESH: thresh_reg = data[31:0];
      default: ;
    endcase
  endtask

  // Entry order: h00 h01 h02 h10 h11 h12 h20 h21.
  task automatic load_homography(input logic [7:0][31:0] h, input logic [63:0] thr);
    write_reg(REG_ROW0_A, {h[0], h[1]});
    write_reg(REG_ROW0_B, {h[2], h[3]});
    write_reg(REG_ROW1,   {h[4], h[5]});
    write_reg(REG_ROW2,   {h[6], h[7]});
    write_reg(REG_THRESH, thr);
  endtask

  function automatic in_word_t make_pair(input logic [31:0] sx, sy, sw, dx, dy, dw,
                                         input logic last);
    in_word_t w;
    w.src_x = sx;
    w.src_y = sy;
    w.src_w = sw;
    w.dst_x = dx;
    w.dst_y = dy;
    w.dst_w = dw;
    w.last_pair = last;
    return w;
  endfunction

  // A correspondence that lies near the projection: the destination is the projected point
  // plus a small offset on the scale of the threshold, so both outcomes are common.
  task automatic send_matched(input bit last);
    in_word_t            w;
    logic signed [511:0] px, py, pw;
    int unsigned         span;
    w = make_pair($urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000,
                  $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000,
                  Q_ONE + jitter(32'h0010_0000), '0, '0, '0, last);
    project_point(w, px, py, pw);
    span = (thresh_reg > 32'h0008_0000) ? 32'h0010_0000 : 2 * thresh_reg + 1;
    w.dst_x = px[FRAC_SHIFT +: 32] + jitter(span);
    w.dst_y = py[FRAC_SHIFT +: 32] + jitter(span);
    w.dst_w = pw[FRAC_SHIFT +: 32];
    // Negating a whole homogeneous vector leaves the point where it was.
    if ($urandom_range(0, 1)) begin
      w.src_x = -w.src_x;
      w.src_y = -w.src_y;
      w.src_w = -w.src_w;
    end
    if ($urandom_range(0, 1)) begin
      w.dst_x = -w.dst_x;
      w.dst_y = -w.dst_y;
      w.dst_w = -w.dst_w;
    end
    send_pair(w);
  endtask

  // Unstructured word: any bit pattern, with zero weights now and then.
  task automatic send_noise_pair();
    in_word_t w;
    w = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 15) == 0);
    if ($urandom_range(0, 15) == 0) begin
      w.src_w = '0;
    end
    if ($urandom_range(0, 15) == 0) begin
      w.dst_w = '0;
    end
    send_pair(w);
  endtask

  // Straight after reset H is diag(0, 0, 1): every source point projects to the origin.
  task automatic test_default_homography();
    send_pair(make_pair(32'h0280_0000, 32'h1234_5678, Q_ONE, '0, '0, Q_ONE, 1'b0));
    // An offset equal to the default threshold is not strictly below it.
    send_pair(make_pair(32'h0280_0000, '0, Q_ONE, DEFAULT_THRESH, '0, Q_ONE, 1'b0));
    send_pair(make_pair('0, '0, Q_ONE, DEFAULT_THRESH - 1, '0, Q_ONE, 1'b0));
    // A zero source weight gives a zero projected weight, which can never pass.
    send_pair(make_pair('0, '0, '0, '0, '0, Q_ONE, 1'b1));
  endtask

  // Identity homography with the default threshold: exact distance boundaries and weights.
  task automatic test_identity_boundaries();
    logic [7:0][31:0] h;
    logic [31:0]      sx, sy;
    wait_drained();
    h = '0;
    h[0] = Q_ONE;
    h[4] = Q_ONE;
    load_homography(h, {32'h0, DEFAULT_THRESH});
    sx = 32'h0280_0000;
    sy = 32'hFEC0_0000;
    send_pair(make_pair(sx, sy, Q_ONE, sx, sy, Q_ONE, 1'b0));
    send_pair(make_pair(sx, sy, Q_ONE, sx + DEFAULT_THRESH - 1, sy, Q_ONE, 1'b0));
    send_pair(make_pair(sx, sy, Q_ONE, sx + DEFAULT_THRESH, sy, Q_ONE, 1'b0));
    // Just inside and just outside the circle along the diagonal.
    send_pair(make_pair(sx, sy, Q_ONE, sx + 32'd59316, sy + 32'd59316, Q_ONE, 1'b0));
    send_pair(make_pair(sx, sy, Q_ONE, sx + 32'd59317, sy + 32'd59317, Q_ONE, 1'b0));
    // The same point written with a different scale and with flipped signs.
    send_pair(make_pair(sx, sy, Q_ONE, sx << 1, sy << 1, Q_ONE << 1, 1'b0));
    send_pair(make_pair(sx, sy, Q_ONE, -sx, -sy, -Q_ONE, 1'b0));
    send_pair(make_pair(sx, sy, '0, sx, sy, Q_ONE, 1'b0));
    send_pair(make_pair(sx, sy, Q_ONE, sx, sy, '0, 1'b1));
    // Most positive and most negative fields.
    send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
  endtask

  // Zero and full-scale thresholds, then writes to unused indexes that must change nothing.
  task automatic test_threshold_extremes();
    wait_drained();
    write_reg(REG_THRESH, {32'hFFFF_FFFF, 32'h0});
    send_pair(make_pair(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1));
    wait_drained();
    write_reg(REG_THRESH, {32'h0, 32'hFFFF_FFFF});
    send_pair(make_pair(Q_ONE, Q_ONE, Q_ONE, 32'h7FFF_FFFF, 32'h8000_0000, Q_ONE, 1'b0));
    send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    wait_drained();
    for (int i = REG_THRESH + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
    end
    send_pair(make_pair(Q_ONE, Q_ONE, Q_ONE, 32'h7FFF_FFFF, 32'h8000_0000, Q_ONE, 1'b1));
  endtask

  // Phases with fresh configurations. Most words are near-matches; the rest are noise.
  // Phase 2 runs without idling on either side, phase 3 uses the largest threshold, phase 4
  // fully random coefficients and phase 5 a zero threshold.
  task automatic test_random_sets();
    logic [7:0][31:0] h;
    logic [63:0]      thr;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      h[0] = Q_ONE + jitter(32'h0040_0000);
      h[1] = jitter(32'h0040_0000);
      h[2] = jitter(32'h0100_0000);
      h[3] = jitter(32'h0040_0000);
      h[4] = Q_ONE + jitter(32'h0040_0000);
      h[5] = jitter(32'h0100_0000);
      h[6] = jitter(32'h0000_0400);
      h[7] = jitter(32'h0000_0400);
      if (phase == 4) begin
        for (int k = 0; k < 8; k++) begin
          h[k] = $urandom;
        end
      end
      thr = {$urandom, $urandom_range(1, 32'h0010_0000)};
      if (phase == 3) begin
        thr[31:0] = 32'hFFFF_FFFF;
      end else if (phase == 5) begin
        thr[31:0] = 32'h0;
      end
      load_homography(h, thr);
      in_idle_en   = (phase != 2);
      out_stall_en = (phase != 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Once mid-stream the sender waits for every outstanding result before going on.
        if (phase == 1 && n == PHASE_WORDS / 2) begin
          wait_drained();
        end
        if ($urandom_range(0, 99) < 80) begin
          send_matched($urandom_range(0, 15) == 0);
        end else begin
          send_noise_pair();
        end
      end
    end
    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < 4; i++) begin
      coef_regs[i] = '0;
    end
    thresh_reg = DEFAULT_THRESH;
    set_tally  = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_default_homography();
    test_identity_boundaries();
    test_threshold_extremes();
    test_random_sets();

    wait_drained();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/hil_pkg.sv
sv/hil_smul.sv
sv/hil_proj.sv
sv/hil_resid.sv
sv/hil_test.sv
sv/homography_inlier_scorer_top.sv
tb/homography_inlier_scorer_top_tb.sv
